// ===== src/read_ahead_window_controller_assert.svh =====
// Assertion macros used by the read-ahead window controller RTL.
`ifndef READ_AHEAD_WINDOW_CONTROLLER_ASSERT_SVH
`define READ_AHEAD_WINDOW_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define RAWC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rawc assertion failed");
`define RAWC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rawc assertion failed");
`else
`define RAWC_ASSERT(label, clk, rst_n, prop)
`define RAWC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/rawc_pkg.sv =====
// Types, constants and helpers of the read-ahead window controller.
package rawc_pkg;
    localparam int POS_W  = 48;
    localparam int RING_W = 21;
    localparam int IDX_W  = 20;
    localparam int LEN_W  = 16;
    localparam int GEN_W  = 32;
    localparam int OP_W   = 3;
    localparam int CNT_W  = 6;

    localparam logic [RING_W-1:0] RING_MIN  = 21'd4096;
    localparam logic [RING_W-1:0] RING_MAX  = 21'd1048576;
    localparam logic [RING_W-1:0] RING_RST  = 21'd4096;
    localparam logic [LEN_W-1:0]  CHUNK_RST = 16'd2048;
    localparam logic [LEN_W-1:0]  KEEP_RST  = 16'd512;
    localparam logic [RING_W+1:0] HORIZON_GUARD = 23'd4;
    localparam logic [POS_W-1:0]  POS_MAX = {POS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CONSUME   = 3'd0,
        OP_SEEK      = 3'd1,
        OP_INVAL     = 3'd2,
        OP_FILL_REQ  = 3'd3,
        OP_FILL_DONE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_COPY   = 2'd1,
        KIND_FETCH  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTHING = 2'd1,
        ST_STALE   = 2'd2,
        ST_MOVED   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_RING   = 2'd1,
        CFG_CHUNK  = 2'd2,
        CFG_KEEP   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_EXEC, S_RDY, S_DIV, S_SEG0, S_SEG1, S_STAT
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic exec;
        logic rdy;
        logic div_init;
        logic div_step;
        logic load_seg0;
        logic load_seg1;
        logic load_stat;
    } t_dp_cmd;

    typedef struct packed {
        logic has_seg;
        logic div_done;
        logic two_seg;
        logic out_free;
    } t_dp_sts;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction
endpackage

// ===== src/rawc_if.sv =====
// Valid/ready channel interfaces for command words and result words.
interface rawc_in_if;
    logic                          valid;
    logic                          ready;
    logic [rawc_pkg::OP_W-1:0]     operation;
    logic [rawc_pkg::POS_W-1:0]    position;
    logic [rawc_pkg::LEN_W-1:0]    block_length;
    modport source (output valid, operation, position, block_length, input ready);
    modport sink   (input valid, operation, position, block_length, output ready);
endinterface

interface rawc_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [rawc_pkg::IDX_W-1:0]    ring_index;
    logic [rawc_pkg::LEN_W-1:0]    count;
    logic [rawc_pkg::LEN_W-1:0]    block_offset;
    logic [rawc_pkg::POS_W-1:0]    source_position;
    logic [1:0]                    status;
    logic [rawc_pkg::RING_W-1:0]   ready_count;
    logic                          last;
    modport source (output valid, kind, ring_index, count, block_offset, source_position,
                    status, ready_count, last, input ready);
    modport sink   (input valid, kind, ring_index, count, block_offset, source_position,
                    status, ready_count, last, output ready);
endinterface

// ===== src/read_ahead_window_controller.sv =====
// Read-ahead window controller: top level joining controller and datapath.
// One command word at a time. Every word passes through capture, the planning states
// PREP and EXEC and the ready-count state RDY; a word that produces a copy or fetch
// segment then runs the bit-serial remainder unit (slot = position mod ring size), one
// bit per cycle over 48 position bits, and gives one or two segment words, while a
// status-only word gives a single status word.
// The next command word is taken while the last result word still waits.
module read_ahead_window_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [rawc_pkg::RING_W-1:0]  i_cfg_data,
    rawc_in_if.sink                      i_in,
    rawc_out_if.source                   o_out
);
    rawc_pkg::t_dp_cmd w_cmd;
    rawc_pkg::t_dp_sts w_sts;

    rawc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rawc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_in.operation),
        .i_position        (i_in.position),
        .i_block_length    (i_in.block_length),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_kind            (o_out.kind),
        .o_ring_index      (o_out.ring_index),
        .o_count           (o_out.count),
        .o_block_offset    (o_out.block_offset),
        .o_source_position (o_out.source_position),
        .o_status          (o_out.status),
        .o_ready_count     (o_out.ready_count),
        .o_last            (o_out.last)
    );
endmodule

// ===== src/rawc_dp.sv =====
// Datapath: window state, config registers, fetch/copy planning, remainder unit, output word.
module rawc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [rawc_pkg::RING_W-1:0]   i_cfg_data,
    input  logic [rawc_pkg::OP_W-1:0]     i_op,
    input  logic [rawc_pkg::POS_W-1:0]    i_position,
    input  logic [rawc_pkg::LEN_W-1:0]    i_block_length,
    input  rawc_pkg::t_dp_cmd             i_cmd,
    output rawc_pkg::t_dp_sts             o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_kind,
    output logic [rawc_pkg::IDX_W-1:0]    o_ring_index,
    output logic [rawc_pkg::LEN_W-1:0]    o_count,
    output logic [rawc_pkg::LEN_W-1:0]    o_block_offset,
    output logic [rawc_pkg::POS_W-1:0]    o_source_position,
    output logic [1:0]                    o_status,
    output logic [rawc_pkg::RING_W-1:0]   o_ready_count,
    output logic                          o_last
);
    localparam int PW = rawc_pkg::POS_W;
    localparam int RW = rawc_pkg::RING_W;
    localparam int LW = rawc_pkg::LEN_W;

    // config
    logic          r_en;
    logic [RW-1:0] r_ring_size;
    logic [LW-1:0] r_chunk, r_keep;

    // window state
    logic [PW-1:0] r_play, r_ws, r_we, r_pst, r_pend;
    logic [rawc_pkg::GEN_W-1:0] r_gen, r_pgen;
    logic r_prst, r_pval;

    // item and work registers
    logic [rawc_pkg::OP_W-1:0] r_op;
    logic [PW-1:0] r_posin;
    logic [LW-1:0] r_len;
    logic [PW-1:0] r_target, r_recand, r_rs, r_endq, r_from;
    logic          r_restart;
    logic          r_has_seg;
    logic [1:0]    r_kind;
    logic [1:0]    r_status;
    logic [PW-1:0] r_seg_start;
    logic [LW-1:0] r_seg_len, r_seg_off, r_n0;
    logic [RW-1:0] r_ready;

    // remainder unit
    logic [PW-1:0] r_dvd;
    logic [RW-1:0] r_rem;
    logic [rawc_pkg::CNT_W-1:0] r_cnt;

    // output word
    logic                r_out_valid;
    logic [1:0]          r_o_kind, r_o_status;
    logic [rawc_pkg::IDX_W-1:0] r_o_idx;
    logic [LW-1:0]       r_o_count, r_o_off;
    logic [PW-1:0]       r_o_src;
    logic [RW-1:0]       r_o_ready;
    logic                r_o_last;

    logic [RW-1:0]   w_ring;
    logic [RW+1:0]   w_h;
    logic            w_h_pos;
    logic [PW-1:0]   w_h_val, w_base, w_ext_base, w_to, w_re, w_lo, w_diff;
    logic            w_inwin, w_fetch_ok;
    logic [RW:0]     w_trial;
    logic [RW-1:0]   w_room;
    logic            w_two;
    logic [LW-1:0]   w_n0;
    logic            w_has_seg;
    logic [1:0]      w_status;

    always_comb begin
        if (r_ring_size < rawc_pkg::RING_MIN) begin
            w_ring = rawc_pkg::RING_MIN;
        end else if (r_ring_size > rawc_pkg::RING_MAX) begin
            w_ring = rawc_pkg::RING_MAX;
        end else begin
            w_ring = r_ring_size;
        end
        w_h     = {2'b00, w_ring} - {{(RW+2-LW){1'b0}}, r_keep} - rawc_pkg::HORIZON_GUARD;
        w_h_pos = !w_h[RW+1] && (w_h != '0);
        w_h_val = {{(PW-RW){1'b0}}, w_h[RW-1:0]};

        // invalidate plans from the new position with the window cleared
        w_base     = (r_op == rawc_pkg::OP_INVAL) ? r_posin : r_play;
        w_inwin    = (r_op != rawc_pkg::OP_INVAL) && (r_play >= r_ws) && (r_play < r_we);
        w_ext_base = w_inwin ? r_we : w_base;

        w_to       = (r_endq < r_we) ? r_endq : r_we;
        w_re       = (r_recand < r_target) ? r_recand : r_target;
        w_fetch_ok = r_en && w_h_pos && (w_re > r_rs);
        w_lo       = (r_pend >= {{(PW-RW){1'b0}}, w_ring})
                   ? r_pend - {{(PW-RW){1'b0}}, w_ring} + PW'(1) : '0;
        w_diff     = r_we - r_play;

        w_trial = {r_rem, r_dvd[PW-1]};
        w_room  = w_ring - r_rem;
        w_two   = {{(RW-LW){1'b0}}, r_seg_len} > w_room;
        w_n0    = w_two ? w_room[LW-1:0] : r_seg_len;

        // segment flag and status of the item, from the state before it
        w_has_seg = 1'b0;
        w_status  = rawc_pkg::ST_NOTHING;
        if (r_op == rawc_pkg::OP_CONSUME) begin
            w_has_seg = (r_len != '0) && r_en && (w_to > r_from);
        end else if (r_op == rawc_pkg::OP_SEEK) begin
            w_status = rawc_pkg::ST_OK;
        end else if (r_op == rawc_pkg::OP_INVAL) begin
            w_has_seg = w_fetch_ok;
            w_status  = rawc_pkg::ST_OK;
        end else if (r_op == rawc_pkg::OP_FILL_REQ) begin
            w_has_seg = !r_pval && w_fetch_ok;
        end else if (r_op == rawc_pkg::OP_FILL_DONE && r_pval) begin
            if (r_pgen != r_gen) begin
                w_status = rawc_pkg::ST_STALE;
            end else if (r_prst && (r_play < r_pst || r_play >= r_pend)) begin
                w_status = rawc_pkg::ST_MOVED;
            end else begin
                w_status = rawc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b0;
            r_ring_size <= rawc_pkg::RING_RST;
            r_chunk     <= rawc_pkg::CHUNK_RST;
            r_keep      <= rawc_pkg::KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (rawc_pkg::t_cfg_idx'(i_cfg_idx))
                rawc_pkg::CFG_ENABLE: r_en        <= i_cfg_data[0];
                rawc_pkg::CFG_RING:   r_ring_size <= i_cfg_data;
                rawc_pkg::CFG_CHUNK:  r_chunk     <= i_cfg_data[LW-1:0];
                rawc_pkg::CFG_KEEP:   r_keep      <= i_cfg_data[LW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play <= '0; r_ws <= '0; r_we <= '0;
            r_gen  <= '0; r_pgen <= '0;
            r_pst  <= '0; r_pend <= '0;
            r_prst <= 1'b0; r_pval <= 1'b0;
            r_has_seg <= 1'b0;
        end else if (i_cmd.exec) begin
            r_has_seg <= w_has_seg;
            unique case (r_op)
                rawc_pkg::OP_CONSUME: begin
                    if (r_len != '0) begin
                        r_play <= r_endq;
                    end
                end
                rawc_pkg::OP_SEEK: r_play <= r_posin;
                rawc_pkg::OP_INVAL: begin
                    r_ws   <= '0;
                    r_we   <= '0;
                    r_gen  <= r_gen + 1'b1;
                    r_play <= r_posin;
                    if (r_en) begin
                        r_pval <= w_fetch_ok;
                        if (w_fetch_ok) begin
                            r_pst <= r_rs; r_pend <= w_re; r_prst <= r_restart;
                            r_pgen <= r_gen + 1'b1;
                        end
                    end
                end
                rawc_pkg::OP_FILL_REQ: begin
                    if (!r_pval && w_fetch_ok) begin
                        r_pval <= 1'b1;
                        r_pst <= r_rs; r_pend <= w_re; r_prst <= r_restart;
                        r_pgen <= r_gen;
                    end
                end
                rawc_pkg::OP_FILL_DONE: begin
                    if (r_pval) begin
                        r_pval <= 1'b0;
                        if (r_pgen == r_gen) begin
                            if (r_prst) begin
                                if (r_play >= r_pst && r_play < r_pend) begin
                                    r_ws <= r_pst;
                                    r_we <= r_pend;
                                end
                            end else begin
                                r_we <= r_pend;
                                if (w_lo > r_ws) r_ws <= w_lo;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers for the item, segment planning, ready count and remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_posin <= i_position;
            r_len   <= i_block_length;
        end
        if (i_cmd.prep) begin
            r_target  <= rawc_pkg::sat_add(w_base, w_h_val);
            r_recand  <= rawc_pkg::sat_add(w_ext_base, {{(PW-LW){1'b0}}, r_chunk});
            r_rs      <= w_ext_base;
            r_restart <= !w_inwin;
            r_endq    <= rawc_pkg::sat_add(r_play, {{(PW-LW){1'b0}}, r_len});
            r_from    <= (r_play > r_ws) ? r_play : r_ws;
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            if (r_op == rawc_pkg::OP_CONSUME) begin
                r_kind      <= rawc_pkg::KIND_COPY;
                r_seg_start <= r_from;
                r_seg_len   <= LW'(w_to - r_from);
                r_seg_off   <= LW'(r_from - r_play);
            end else begin
                r_kind      <= rawc_pkg::KIND_FETCH;
                r_seg_start <= r_rs;
                r_seg_len   <= LW'(w_re - r_rs);
                r_seg_off   <= '0;
            end
        end
        if (i_cmd.rdy) begin
            if (r_play >= r_ws && r_play < r_we) begin
                r_ready <= (w_diff > {{(PW-RW){1'b0}}, w_ring}) ? w_ring : w_diff[RW-1:0];
            end else begin
                r_ready <= '0;
            end
        end
        if (i_cmd.div_init) begin
            r_dvd <= r_seg_start;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[PW-2:0], 1'b0};
            if (w_trial >= {1'b0, w_ring}) begin
                r_rem <= RW'(w_trial - {1'b0, w_ring});
            end else begin
                r_rem <= w_trial[RW-1:0];
            end
        end
        if (i_cmd.load_seg0) begin
            r_n0 <= w_n0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_cnt <= rawc_pkg::CNT_W'(PW);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_seg0 || i_cmd.load_seg1 || i_cmd.load_stat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seg0) begin
            r_o_kind   <= r_kind;
            r_o_idx    <= r_rem[rawc_pkg::IDX_W-1:0];
            r_o_count  <= w_n0;
            r_o_off    <= r_seg_off;
            r_o_src    <= r_seg_start;
            r_o_status <= rawc_pkg::ST_OK;
            r_o_ready  <= r_ready;
            r_o_last   <= !w_two;
        end else if (i_cmd.load_seg1) begin
            r_o_kind   <= r_kind;
            r_o_idx    <= '0;
            r_o_count  <= r_seg_len - r_n0;
            r_o_off    <= r_seg_off + r_n0;
            r_o_src    <= rawc_pkg::sat_add(r_seg_start, {{(PW-LW){1'b0}}, r_n0});
            r_o_status <= rawc_pkg::ST_OK;
            r_o_ready  <= r_ready;
            r_o_last   <= 1'b1;
        end else if (i_cmd.load_stat) begin
            r_o_kind   <= rawc_pkg::KIND_STATUS;
            r_o_idx    <= '0;
            r_o_count  <= '0;
            r_o_off    <= '0;
            r_o_src    <= r_play;
            r_o_status <= r_status;
            r_o_ready  <= r_ready;
            r_o_last   <= 1'b1;
        end
    end

    assign o_sts.has_seg  = r_has_seg;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.two_seg  = w_two;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_o_kind;
    assign o_ring_index      = r_o_idx;
    assign o_count           = r_o_count;
    assign o_block_offset    = r_o_off;
    assign o_source_position = r_o_src;
    assign o_status          = r_o_status;
    assign o_ready_count     = r_o_ready;
    assign o_last            = r_o_last;
endmodule

// ===== src/rawc_ctrl.sv =====
// Controller: sequences capture, planning, remainder and result words for one item.
`include "read_ahead_window_controller_assert.svh"
module rawc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rawc_pkg::t_dp_sts i_sts,
    output rawc_pkg::t_dp_cmd o_cmd
);
    rawc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rawc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rawc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = rawc_pkg::S_PREP;
                end
            end
            rawc_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = rawc_pkg::S_EXEC;
            end
            rawc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = rawc_pkg::S_RDY;
            end
            rawc_pkg::S_RDY: begin
                o_cmd.rdy = 1'b1;
                if (i_sts.has_seg) begin
                    o_cmd.div_init = 1'b1;
                    n_state = rawc_pkg::S_DIV;
                end else begin
                    n_state = rawc_pkg::S_STAT;
                end
            end
            rawc_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = rawc_pkg::S_SEG0;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            rawc_pkg::S_SEG0: begin
                if (i_sts.out_free) begin
                    o_cmd.load_seg0 = 1'b1;
                    n_state = i_sts.two_seg ? rawc_pkg::S_SEG1 : rawc_pkg::S_IDLE;
                end
            end
            rawc_pkg::S_SEG1: begin
                if (i_sts.out_free) begin
                    o_cmd.load_seg1 = 1'b1;
                    n_state = rawc_pkg::S_IDLE;
                end
            end
            rawc_pkg::S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_stat = 1'b1;
                    n_state = rawc_pkg::S_IDLE;
                end
            end
        endcase
    end

    `RAWC_ASSERT(a_accept_to_prep, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == rawc_pkg::S_PREP))
    `RAWC_ASSERT(a_seg1_after_seg0, i_clk, i_rst_n, (r_state == rawc_pkg::S_SEG1) |-> ($past(r_state) == rawc_pkg::S_SEG0 || $past(r_state) == rawc_pkg::S_SEG1))
    `RAWC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == rawc_pkg::S_IDLE))
endmodule

// ===== tb/tb_read_ahead_window_controller.sv =====
// Self-checking testbench for the read-ahead window controller.
`timescale 1ns / 1ps

module tb_read_ahead_window_controller;
    import rawc_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  ring_index;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  block_offset;
        logic [POS_W-1:0]  source_position;
        logic [1:0]        status;
        logic [RING_W-1:0] ready_count;
        logic              last;
    } t_seg;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        bit               typed;
        t_status          st;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [RING_W-1:0] i_cfg_data = '0;

    rawc_in_if  cmd_ch ();
    rawc_out_if seg_ch ();

    read_ahead_window_controller uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (cmd_ch),
        .o_out     (seg_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow configuration and window state
    logic              m_enable;
    logic [RING_W-1:0] m_ring_cfg;
    logic [LEN_W-1:0]  m_chunk, m_keep;
    logic [POS_W-1:0]  m_play, m_wstart, m_wend, m_pstart, m_pend;
    logic [GEN_W-1:0]  m_gen, m_pgen;
    logic              m_prestart, m_pvalid;

    t_seg seg_q[$];
    bit   typed_q[$];
    t_status typed_st_q[$];

    int  mismatches = 0;
    int  n_copy = 0, n_fetch = 0, n_stat = 0, n_words = 0;
    bit  gaps_on = 1'b1;
    int  hold_ask = 0;
    int  idle_cycles = 0;

    function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] ring_slots();
        if (m_ring_cfg < 21'd4096) return 48'd4096;
        if (m_ring_cfg > 21'd1048576) return 48'd1048576;
        return {27'd0, m_ring_cfg};
    endfunction

    function automatic logic [RING_W-1:0] samples_ready();
        logic [POS_W-1:0] r;
        if (m_play < m_wstart || m_play >= m_wend) return '0;
        r = m_wend - m_play;
        if (r > ring_slots()) r = ring_slots();
        return r[RING_W-1:0];
    endfunction

    function automatic void add_seg(logic [1:0] kind, logic [POS_W-1:0] idx,
                                    logic [POS_W-1:0] cnt, logic [POS_W-1:0] off,
                                    logic [POS_W-1:0] src, logic [1:0] st);
        t_seg s;
        s.kind = kind;
        s.ring_index = idx[IDX_W-1:0];
        s.count = cnt[LEN_W-1:0];
        s.block_offset = off[LEN_W-1:0];
        s.source_position = src;
        s.status = st;
        s.ready_count = '0;
        s.last = 1'b0;
        seg_q.push_back(s);
    endfunction

    // range -> one or two ring segments, split at the wrap
    function automatic int split_range(logic [1:0] kind, logic [POS_W-1:0] start,
                                       logic [POS_W-1:0] len, logic [POS_W-1:0] off);
        logic [POS_W-1:0] ring, idx, n;
        ring = ring_slots();
        idx = start % ring;
        n = (len < ring - idx) ? len : ring - idx;
        add_seg(kind, idx, n, off, start, ST_OK);
        if (len > n) begin
            add_seg(kind, '0, len - n, off + n, pos_add(start, n), ST_OK);
            return 2;
        end
        return 1;
    endfunction

    function automatic int plan_fetch();
        logic [POS_W-1:0] rs, re, target;
        int horizon;
        bit restart;
        if (!m_enable) return 0;
        horizon = int'(ring_slots()) - int'(m_keep) - 4;
        if (horizon <= 0) return 0;
        target = pos_add(m_play, POS_W'(horizon));
        if (m_play < m_wstart || m_play >= m_wend) begin
            rs = m_play;
            re = pos_add(m_play, {32'd0, m_chunk});
            restart = 1'b1;
        end else if (m_wend < target) begin
            rs = m_wend;
            re = pos_add(m_wend, {32'd0, m_chunk});
            restart = 1'b0;
        end else begin
            return 0;
        end
        if (re > target) re = target;
        if (re <= rs) return 0;
        m_pstart = rs;
        m_pend = re;
        m_prestart = restart;
        m_pgen = m_gen;
        m_pvalid = 1'b1;
        return split_range(KIND_FETCH, rs, re - rs, '0);
    endfunction

    // expected result words of one accepted command word
    function automatic void predict_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [LEN_W-1:0] len, bit typed, t_status tst);
        logic [POS_W-1:0] endq, from, upto, lo;
        logic [1:0] st;
        int n, base;
        st = ST_NOTHING;
        n = 0;
        base = seg_q.size();
        if (op == OP_CONSUME && len != 0) begin
            endq = pos_add(m_play, {32'd0, len});
            from = (m_play > m_wstart) ? m_play : m_wstart;
            upto = (endq < m_wend) ? endq : m_wend;
            lo = m_play;
            m_play = endq;
            if (m_enable && upto > from) n = split_range(KIND_COPY, from, upto - from, from - lo);
        end else if (op == OP_SEEK) begin
            m_play = pos;
            st = ST_OK;
        end else if (op == OP_INVAL) begin
            m_wstart = '0;
            m_wend = '0;
            m_gen++;
            m_play = pos;
            st = ST_OK;
            if (m_enable) begin
                m_pvalid = 1'b0;
                n = plan_fetch();
            end
        end else if (op == OP_FILL_REQ) begin
            if (!m_pvalid) n = plan_fetch();
        end else if (op == OP_FILL_DONE && m_pvalid) begin
            m_pvalid = 1'b0;
            if (m_pgen != m_gen) begin
                st = ST_STALE;
            end else if (m_prestart) begin
                if (m_play < m_pstart || m_play >= m_pend) begin
                    st = ST_MOVED;
                end else begin
                    m_wstart = m_pstart;
                    m_wend = m_pend;
                    st = ST_OK;
                end
            end else begin
                m_wend = m_pend;
                lo = (m_wend >= ring_slots()) ? m_wend - ring_slots() + 1 : '0;
                if (lo > m_wstart) m_wstart = lo;
                st = ST_OK;
            end
        end
        if (n == 0) begin
            add_seg(KIND_STATUS, '0, '0, '0, m_play, st);
            n = 1;
        end
        for (int k = base; k < seg_q.size(); k++) seg_q[k].ready_count = samples_ready();
        seg_q[seg_q.size() - 1].last = 1'b1;
        if (typed && seg_q[seg_q.size() - 1].status != tst) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row: status %0d, table says %0d",
                         seg_q[seg_q.size() - 1].status, tst);
        end
    endfunction

    function automatic void check_word();
        t_seg e;
        bit bad;
        n_words++;
        if (seg_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $time);
            return;
        end
        e = seg_q.pop_front();
        bad = (seg_ch.kind !== e.kind) || (seg_ch.ring_index !== e.ring_index) ||
              (seg_ch.count !== e.count) || (seg_ch.block_offset !== e.block_offset) ||
              (seg_ch.source_position !== e.source_position) ||
              (seg_ch.status !== e.status) || (seg_ch.ready_count !== e.ready_count) ||
              (seg_ch.last !== e.last);
        case (e.kind)
            KIND_COPY:  n_copy++;
            KIND_FETCH: n_fetch++;
            default:    n_stat++;
        endcase
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t", $time);
                $display("  exp kind %0d idx %0d cnt %0d off %0d src %0h st %0d rdy %0d last %0d",
                         e.kind, e.ring_index, e.count, e.block_offset, e.source_position,
                         e.status, e.ready_count, e.last);
                $display("  got kind %0d idx %0d cnt %0d off %0d src %0h st %0d rdy %0d last %0d",
                         seg_ch.kind, seg_ch.ring_index, seg_ch.count, seg_ch.block_offset,
                         seg_ch.source_position, seg_ch.status, seg_ch.ready_count,
                         seg_ch.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                predict_word(cmd_ch.operation, cmd_ch.position, cmd_ch.block_length,
                             typed_q.pop_front(), typed_st_q.pop_front());
            if (seg_ch.valid && seg_ch.ready) check_word();
            if ((cmd_ch.valid && cmd_ch.ready) || (seg_ch.valid && seg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("read_ahead_window_controller regression: fail");
                $finish;
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int hold;
        hold = 0;
        seg_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask > 0) begin
                hold = hold_ask;
                hold_ask = 0;
            end
            if (hold > 0) begin
                seg_ch.ready = 1'b0;
                hold--;
            end else begin
                seg_ch.ready = gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
            end
        end
    end

    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [LEN_W-1:0] len, bit typed = 1'b0,
                             t_status tst = ST_OK);
        while (gaps_on && $urandom_range(99) < 11) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        typed_q.push_back(typed);
        typed_st_q.push_back(tst);
        cmd_ch.valid = 1'b1;
        cmd_ch.operation = op;
        cmd_ch.position = pos;
        cmd_ch.block_length = len;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [RING_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            CFG_ENABLE: m_enable = val[0];
            CFG_RING:   m_ring_cfg = val;
            CFG_CHUNK:  m_chunk = val[LEN_W-1:0];
            default:    m_keep = val[LEN_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        cmd_ch.valid = 1'b0;
        while (seg_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(logic en, logic [RING_W-1:0] ring, logic [LEN_W-1:0] chunk,
                              logic [LEN_W-1:0] keep);
        write_reg(CFG_ENABLE, {20'd0, en});
        write_reg(CFG_RING, ring);
        write_reg(CFG_CHUNK, {5'd0, chunk});
        write_reg(CFG_KEEP, {5'd0, keep});
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'({$urandom, $urandom});
    endfunction

    task automatic random_word();
        int r;
        logic [LEN_W-1:0] len;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0:       len = LEN_W'($urandom);
            1:       len = 16'hFFFF;
            2:       len = '0;
            default: len = LEN_W'($urandom_range(1, 600));
        endcase
        if (r < 38)      send_word(OP_CONSUME, rand_pos(), len);
        else if (r < 60) send_word(OP_FILL_REQ, rand_pos(), len);
        else if (r < 82) send_word(OP_FILL_DONE, rand_pos(), len);
        else if (r < 88) send_word(OP_SEEK, pos_add(m_play, POS_W'($urandom_range(0, 3000))),
                                   len);
        else if (r < 91) send_word(OP_SEEK, m_play - $urandom_range(0, 3000), len);
        else if (r < 94) send_word(OP_INVAL, m_play + $urandom_range(0, 5000), len);
        else if (r < 96) send_word(OP_SEEK, rand_pos(), len);
        else if (r < 98) send_word($urandom_range(1) ? OP_INVAL : OP_SEEK,
                                   {POS_W{1'b1}} - $urandom_range(0, 70000), len);
        else             send_word(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_pos(), len);
    endtask

    initial begin
        t_row rows[$];
        logic [POS_W-1:0] top;
        top = {POS_W{1'b1}};
        m_enable = 1'b0; m_ring_cfg = RING_RST; m_chunk = CHUNK_RST; m_keep = KEEP_RST;
        m_play = '0; m_wstart = '0; m_wend = '0; m_pstart = '0; m_pend = '0;
        m_gen = '0; m_pgen = '0; m_prestart = 1'b0; m_pvalid = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = OP_CONSUME;
        cmd_ch.position = '0;
        cmd_ch.block_length = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset-state checks with the block still disabled
        send_word(OP_CONSUME, '0, '0, 1'b1, ST_NOTHING);
        send_word(OP_FILL_REQ, '0, '0, 1'b1, ST_NOTHING);
        drain();
        write_reg(CFG_ENABLE, 21'd1);

        rows = '{
            '{OP_CONSUME,   48'd0,      16'd0,     1'b1, ST_NOTHING},
            '{OP_SEEK,      48'd100,    16'd0,     1'b1, ST_OK},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_NOTHING},
            '{OP_FILL_REQ,  48'd0,      16'd0,     1'b0, ST_OK},
            '{OP_FILL_REQ,  48'd0,      16'd0,     1'b1, ST_NOTHING},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_OK},
            '{OP_CONSUME,   48'd0,      16'd300,   1'b0, ST_OK},
            '{OP_FILL_REQ,  48'd0,      16'd0,     1'b0, ST_OK},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_OK},
            '{OP_CONSUME,   48'd0,      16'hFFFF,  1'b0, ST_OK},
            '{OP_SEEK,      48'd4000,   16'd0,     1'b1, ST_OK},
            '{OP_FILL_REQ,  48'd0,      16'd0,     1'b0, ST_OK},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_OK},
            '{OP_CONSUME,   48'd0,      16'd1000,  1'b0, ST_OK},
            '{OP_SEEK,      48'd100000, 16'd0,     1'b1, ST_OK},
            '{OP_FILL_REQ,  48'd0,      16'd0,     1'b0, ST_OK},
            '{OP_SEEK,      48'd0,      16'd0,     1'b1, ST_OK},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_MOVED},
            '{OP_INVAL,     48'd5000,   16'd0,     1'b0, ST_OK},
            '{OP_FILL_DONE, 48'd0,      16'd0,     1'b1, ST_OK},
            '{OP_SPARE_LO,  48'd0,      16'd0,     1'b1, ST_NOTHING},
            '{OP_SPARE_HI,  top,        16'hFFFF,  1'b1, ST_NOTHING},
            '{OP_INVAL,     top - 48'd10, 16'd0,   1'b0, ST_OK},
            '{OP_CONSUME,   48'd0,      16'hFFFF,  1'b0, ST_OK},
            '{OP_SEEK,      {24'hAAAAAA, 24'h555555}, 16'd0, 1'b1, ST_OK}
        };
        foreach (rows[i]) send_word(rows[i].op, rows[i].pos, rows[i].len,
                                    rows[i].typed, rows[i].st);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_config(1'b1, 21'd4096, 16'd2048, 16'd512);
                1: set_config(1'b1, 21'd1048576, 16'hFFFF, 16'd0);
                2: set_config(1'b1, 21'd4096, 16'd1, 16'hFFFF);
                3: set_config(1'b0, 21'd8192, 16'd700, 16'd100);
                4: set_config(1'b1, 21'd0, 16'd0, 16'd3);
                5: set_config(1'b1, 21'h1FFFFF, 16'd3000, 16'd100);
                default: set_config(1'b1, 21'($urandom_range(4096, 1048576)),
                                    16'($urandom_range(1, 65535)), 16'($urandom_range(0, 5000)));
            endcase
            gaps_on = (phase != 2);
            if (phase == 1) hold_ask = 400;
            // a re-enable in mid phase leaves stale fetches to discard
            for (int n = 0; n < 200; n++) begin
                if (phase == 3 && n == 100) begin
                    drain();
                    write_reg(CFG_ENABLE, 21'd1);
                end
                random_word();
            end
            drain();
        end

        $display("%0d result words checked: %0d copy, %0d fetch, %0d status-only",
                 n_words, n_copy, n_fetch, n_stat);
        $display("covered wrap splits, saturation near the top position and stale/moved fills");
        if (mismatches == 0 && seg_q.size() == 0) begin
            $display("read_ahead_window_controller regression: pass");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches, seg_q.size());
            $display("read_ahead_window_controller regression: fail");
        end
        $finish;
    end
endmodule
